// ===== rtl/clfe_pkg.sv =====
// Shared types, constants and helper functions for the Content-Length field extractor.
package clfe_pkg;

  localparam int unsigned LitLen = 15;
  localparam int unsigned MatchW = $clog2(LitLen + 1);
  localparam int unsigned ValW = 64;
  localparam int unsigned ProdW = ValW + 4;

  localparam logic [ValW-1:0] PosLimit = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] NegLimit = {1'b1, {(ValW-1){1'b0}}};

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [3:0] {
    PhSearch = 4'b0001,
    PhSkip   = 4'b0010,
    PhDigits = 4'b0100,
    PhDone   = 4'b1000
  } clfe_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } clfe_in_t;

  typedef struct packed {
    logic              found;
    logic signed [63:0] content_length;
  } clfe_out_t;

  // Raw parse outcome handed to the result register
  typedef struct packed {
    logic            found;
    logic            is_negative;
    logic            overflowed;
    logic [ValW-1:0] magnitude;
  } clfe_acc_t;

  function automatic logic [7:0] lit_byte(input logic [MatchW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h43; // C
      4'd1:    b = 8'h6F; // o
      4'd2:    b = 8'h6E; // n
      4'd3:    b = 8'h74; // t
      4'd4:    b = 8'h65; // e
      4'd5:    b = 8'h6E; // n
      4'd6:    b = 8'h74; // t
      4'd7:    b = 8'h2D; // -
      4'd8:    b = 8'h4C; // L
      4'd9:    b = 8'h65; // e
      4'd10:   b = 8'h6E; // n
      4'd11:   b = 8'h67; // g
      4'd12:   b = 8'h74; // t
      4'd13:   b = 8'h68; // h
      4'd14:   b = 8'h3A; // :
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== rtl/clfe_in_reg.sv =====
// Input register stage: holds one accepted byte until the parser takes it.
module clfe_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clfe_pkg::clfe_in_t in_data_i,
  input  logic              sink_ready_i,
  output logic              take_o,
  output clfe_pkg::clfe_in_t item_o
);

  logic               valid_q;
  clfe_pkg::clfe_in_t data_q;
  logic               accept;

  // A closing byte waits for room in the result register; others pass at once
  assign take_o     = valid_q && (!data_q.last_byte || sink_ready_i);
  assign in_stall_o = valid_q && !take_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/clfe_parser.sv =====
// Literal search, strtoll-style accumulation; one byte per cycle on take.
module clfe_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  clfe_pkg::clfe_in_t  item_i,
  output logic                res_valid_o,
  output clfe_pkg::clfe_acc_t res_o
);

  clfe_pkg::clfe_phase_e           phase_q, phase_d;
  logic [clfe_pkg::MatchW-1:0]     match_q, match_d;
  logic                            neg_q, neg_d;
  logic                            ovf_q, ovf_d;
  logic [clfe_pkg::ValW-1:0]       mag_q, mag_d;

  logic [7:0]                      c;
  logic [clfe_pkg::ProdW-1:0]      prod;
  logic [clfe_pkg::ProdW-1:0]      limit;
  logic                            neg_eff;
  logic                            digit_ovf;

  assign c = item_i.data_byte;

  // Sign in force for this byte: a minus sign counts from the next byte
  assign neg_eff = neg_q;

  // m*10 + d by shifts; overflow when it passes the limit of the sign
  assign prod = ({{4{1'b0}}, mag_q} << 3) + ({{4{1'b0}}, mag_q} << 1)
              + {{(clfe_pkg::ProdW-4){1'b0}}, c[3:0]};
  assign limit = {4'b0000, neg_eff ? clfe_pkg::NegLimit : clfe_pkg::PosLimit};
  assign digit_ovf = prod > limit;

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    mag_d   = mag_q;
    unique case (phase_q)
      clfe_pkg::PhSearch: begin
        if (match_q < clfe_pkg::MatchW'(clfe_pkg::LitLen) &&
            c == clfe_pkg::lit_byte(match_q)) begin
          if (match_q == clfe_pkg::MatchW'(clfe_pkg::LitLen - 1)) begin
            match_d = '0;
            phase_d = clfe_pkg::PhSkip;
          end else begin
            match_d = match_q + 1'b1;
          end
        end else begin
          // The literal has no border: only a fresh first byte restarts it
          match_d = (c == clfe_pkg::lit_byte('0)) ? clfe_pkg::MatchW'(1) : '0;
        end
      end
      clfe_pkg::PhSkip: begin
        if (clfe_pkg::is_blank(c)) begin
          phase_d = clfe_pkg::PhSkip;
        end else if (c == clfe_pkg::ChPlus) begin
          phase_d = clfe_pkg::PhDigits;
        end else if (c == clfe_pkg::ChMinus) begin
          neg_d   = 1'b1;
          phase_d = clfe_pkg::PhDigits;
        end else if (clfe_pkg::is_digit(c)) begin
          phase_d = clfe_pkg::PhDigits;
          if (!ovf_q) begin
            if (digit_ovf) ovf_d = 1'b1;
            else           mag_d = prod[clfe_pkg::ValW-1:0];
          end
        end else begin
          phase_d = clfe_pkg::PhDone;
        end
      end
      clfe_pkg::PhDigits: begin
        if (clfe_pkg::is_digit(c)) begin
          if (!ovf_q) begin
            if (digit_ovf) ovf_d = 1'b1;
            else           mag_d = prod[clfe_pkg::ValW-1:0];
          end
        end else begin
          phase_d = clfe_pkg::PhDone;
        end
      end
      clfe_pkg::PhDone: begin
        phase_d = clfe_pkg::PhDone;
      end
      default: begin
        phase_d = clfe_pkg::PhSearch;
      end
    endcase
  end

  assign res_valid_o       = take_i && item_i.last_byte;
  assign res_o.found       = (phase_d != clfe_pkg::PhSearch);
  assign res_o.is_negative = neg_d;
  assign res_o.overflowed  = ovf_d;
  assign res_o.magnitude   = mag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clfe_pkg::PhSearch;
      match_q <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      mag_q   <= '0;
    end else if (take_i) begin
      if (item_i.last_byte) begin
        // End of buffer: drop all parse state
        phase_q <= clfe_pkg::PhSearch;
        match_q <= '0;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
        mag_q   <= '0;
      end else begin
        phase_q <= phase_d;
        match_q <= match_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        mag_q   <= mag_d;
      end
    end
  end

endmodule

// ===== rtl/clfe_out_reg.sv =====
// Result register: holds the parse outcome and forms the signed, saturated length.
module clfe_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  clfe_pkg::clfe_acc_t res_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clfe_pkg::clfe_out_t out_data_o
);

  logic                valid_q;
  clfe_pkg::clfe_acc_t res_q;
  logic [clfe_pkg::ValW-1:0] value;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;

  always_comb begin
    if (!res_q.found) begin
      value = '0;
    end else if (res_q.overflowed) begin
      value = res_q.is_negative ? clfe_pkg::NegLimit : clfe_pkg::PosLimit;
    end else if (res_q.is_negative) begin
      value = '0 - res_q.magnitude;
    end else begin
      value = res_q.magnitude;
    end
  end

  assign out_data_o.found          = res_q.found;
  assign out_data_o.content_length = value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/content_length_field_extractor_top.sv =====
// Top level of the Content-Length field extractor.
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+-------------------------
//  in      | input     | clfe_in_t (byte)   | in_valid_i / in_stall_o
//  out     | output    | clfe_out_t (result)| out_valid_o / out_stall_i
//
// One byte is taken per cycle unless a closing byte waits; the parse state
// loop (literal match and the multiply-by-ten accumulate with its limit
// compare) is registered, as is the result of a closing byte.
// Reset clears the input and result valid flags and all parse state.
// Only a closing byte waits on a stalled output; other bytes keep flowing.
module content_length_field_extractor_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clfe_pkg::clfe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clfe_pkg::clfe_out_t out_data_o
);

  logic                sink_ready;
  logic                take;
  clfe_pkg::clfe_in_t  item;
  logic                res_valid;
  clfe_pkg::clfe_acc_t res;

  clfe_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .sink_ready_i(sink_ready),
    .take_o      (take),
    .item_o      (item)
  );

  clfe_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  clfe_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .ready_o    (sink_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.content_length == '0)
    else $error("result without literal carries a nonzero length");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && item.last_byte)
    else $error("input held back without a blocked closing byte");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> take && item.last_byte && sink_ready)
    else $error("result loaded without room or without a closing byte");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res_valid))
    else $error("output valid rose without a closing byte");

endmodule
